@@ src/ordered_list_insert_delete_find_assert.svh @@
// Assertion helpers for the ordered list block.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef ORDERED_LIST_INSERT_DELETE_FIND_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_FIND_ASSERT_SVH

// Same-cycle implication.
`define OLIDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define OLIDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/olidf_pkg.sv @@
package olidf_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_OVERWRITE = 2'd2,
        OP_FIND      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                     update;
        t_op                      op;
        logic [IDX_W-1:0]         pos0;
        logic                     capture;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

@@ src/olidf_cell.sv @@
module olidf_cell (
    input  logic                              i_clk,
    input  olidf_pkg::t_cell_ctrl             i_ctrl,
    input  logic [olidf_pkg::IDX_W-1:0]       i_idx,
    input  logic signed [olidf_pkg::DATA_W-1:0] i_left,
    input  logic signed [olidf_pkg::DATA_W-1:0] i_right,
    output logic signed [olidf_pkg::DATA_W-1:0] o_data,
    output logic                              o_hit
);
    import olidf_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_hit;
    logic                     n_hit;
    logic                     w_at;
    logic                     w_above;

    assign w_at    = (i_idx == i_ctrl.pos0);
    assign w_above = (i_idx > i_ctrl.pos0);

    always_comb begin
        n_data = r_data;
        n_hit  = r_hit;
        if (i_ctrl.update) begin
            case (i_ctrl.op)
                OP_INSERT: begin
                    if (w_at) begin
                        n_data = i_ctrl.value;
                    end else if (w_above) begin
                        n_data = i_left;
                    end
                end
                OP_DELETE: begin
                    if (w_at || w_above) begin
                        n_data = i_right;
                    end
                end
                OP_OVERWRITE: begin
                    if (w_at) begin
                        n_data = i_ctrl.value;
                    end
                end
                default: begin
                end
            endcase
        end
        // Latch match only for live entries.
        if (i_ctrl.capture) begin
            n_hit = (r_data == i_ctrl.value) && (CNT_W'(i_idx) < i_ctrl.count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

@@ src/ordered_list_insert_delete_find.sv @@
// Ordered list of up to 64 signed 32-bit values kept in a row of cells, one
// entry per cell, with a running count. Insert, delete and overwrite act on
// a 1-based position; every cell decides locally whether to keep its value,
// take the new value or take its neighbor's, so all cells shift together.
// Each item is first held in an input register; an insert, delete or
// overwrite then moves its result into the output register once the output
// side is free, and the next item is taken only once the input register has
// emptied. A find latches a match flag in every cell and then walks the
// cells one per cycle, waiting while a result is due and the output side
// stalls, giving one result per matching position in ascending order with
// last set on the final one, or a single not-found result. One item is worked
// on at a time; o_in_stall is high while an item sits in the input register.
// A full list on insert (status 1) or a position outside the list (status 2)
// leaves the list unchanged. data_out carries the removed value of a delete,
// count_now the count after the item. The output register lets the next item
// be taken while a result still waits.
`include "ordered_list_insert_delete_find_assert.svh"

module ordered_list_insert_delete_find (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_operation,
    input  logic [olidf_pkg::POS_W-1:0]         i_position,
    input  logic signed [olidf_pkg::DATA_W-1:0] i_value_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [olidf_pkg::DATA_W-1:0] o_data_out,
    output logic [olidf_pkg::POS_W-1:0]         o_found_position,
    output logic [olidf_pkg::CNT_W-1:0]         o_count_now,
    output logic                                o_last
);
    import olidf_pkg::*;

    // Input register
    logic                     r_req_valid;
    logic                     n_req_valid;
    t_op                      r_op;
    logic [POS_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] r_val;

    // Control state
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic             r_pend;
    logic             n_pend;
    logic [POS_W-1:0] r_pend_pos;
    logic [POS_W-1:0] n_pend_pos;

    // Output register
    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_data_out;
    logic [POS_W-1:0]         r_fpos;
    logic [CNT_W-1:0]         r_count_now;
    logic                     r_last;

    logic                     w_emit;
    t_status                  w_emit_status;
    logic signed [DATA_W-1:0] w_emit_data;
    logic [POS_W-1:0]         w_emit_fpos;
    logic                     w_emit_last;
    logic                     w_out_free;
    logic                     w_do_simple;

    t_cell_ctrl               w_ctrl;
    logic [IDX_W-1:0]         w_pos0;
    logic signed [DATA_W-1:0] w_cell_data [CAPACITY];
    logic [CAPACITY-1:0]      w_hit_vec;
    logic signed [DATA_W-1:0] w_removed;
    logic                     w_full;
    logic                     w_ins_bad;
    logic                     w_pos_bad;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_req_valid;

    // Valid positions keep pos - 1 inside the row; others never update cells.
    assign w_pos0    = IDX_W'(r_pos - POS_W'(1));
    assign w_full    = (r_count >= CNT_W'(CAPACITY));
    assign w_ins_bad = (r_pos == '0) || ({1'b0, r_pos} > ({1'b0, r_count} + 8'd1));
    assign w_pos_bad = (r_pos == '0) || (r_pos > r_count);

    // Row of cells; each takes its left neighbor on insert, right on delete.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = w_cell_data[k];
        end else begin : g_mid_l
            assign w_left = w_cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_data[k];
        end else begin : g_mid_r
            assign w_right = w_cell_data[k+1];
        end
        olidf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (IDX_W'(k)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[k]),
            .o_hit   (w_hit_vec[k])
        );
    end

    // Pick the addressed entry for delete: one-hot select, OR-combined.
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (IDX_W'(k) == w_pos0) begin
                w_removed = w_removed | w_cell_data[k];
            end
        end
    end

    // Next state, cell commands and result selection.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_idx          = r_idx;
        n_pend         = r_pend;
        n_pend_pos     = r_pend_pos;
        n_req_valid    = r_req_valid;
        w_emit         = 1'b0;
        w_emit_status  = ST_OK;
        w_emit_data    = '0;
        w_emit_fpos    = '0;
        w_emit_last    = 1'b1;
        w_do_simple    = 1'b0;
        w_ctrl.update  = 1'b0;
        w_ctrl.op      = r_op;
        w_ctrl.pos0    = w_pos0;
        w_ctrl.capture = 1'b0;
        w_ctrl.count   = r_count;
        w_ctrl.value   = r_val;

        // Take a new item only when the input register is empty.
        if (i_in_valid && !r_req_valid) begin
            n_req_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (r_req_valid) begin
                    if (r_op == OP_FIND) begin
                        // Latch match flags in all cells, then walk them.
                        w_ctrl.capture = 1'b1;
                        n_idx          = '0;
                        n_pend         = 1'b0;
                        n_state        = S_SCAN;
                    end else if (w_out_free) begin
                        w_do_simple = 1'b1;
                        w_emit      = 1'b1;
                        n_req_valid = 1'b0;
                        case (r_op)
                            OP_INSERT: begin
                                if (w_full) begin
                                    w_emit_status = ST_FULL;
                                end else if (w_ins_bad) begin
                                    w_emit_status = ST_BADPOS;
                                end else begin
                                    w_ctrl.update = 1'b1;
                                    n_count       = r_count + CNT_W'(1);
                                end
                            end
                            OP_DELETE: begin
                                if (w_pos_bad) begin
                                    w_emit_status = ST_BADPOS;
                                end else begin
                                    w_ctrl.update = 1'b1;
                                    n_count       = r_count - CNT_W'(1);
                                    w_emit_data   = w_removed;
                                end
                            end
                            default: begin
                                if (w_pos_bad) begin
                                    w_emit_status = ST_BADPOS;
                                end else begin
                                    w_ctrl.update = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    // End of list: flush the held match as last, or report none.
                    if (w_out_free) begin
                        w_emit        = 1'b1;
                        w_emit_status = r_pend ? ST_OK : ST_NOTFOUND;
                        w_emit_fpos   = r_pend ? r_pend_pos : '0;
                        n_pend        = 1'b0;
                        n_req_valid   = 1'b0;
                        n_state       = S_IDLE;
                    end
                end else if (w_hit_vec[r_idx[IDX_W-1:0]]) begin
                    if (!r_pend) begin
                        n_pend     = 1'b1;
                        n_pend_pos = POS_W'(r_idx + CNT_W'(1));
                        n_idx      = r_idx + CNT_W'(1);
                    end else if (w_out_free) begin
                        // Another match follows, so the held one is not last.
                        w_emit      = 1'b1;
                        w_emit_fpos = r_pend_pos;
                        w_emit_last = 1'b0;
                        n_pend_pos  = POS_W'(r_idx + CNT_W'(1));
                        n_idx       = r_idx + CNT_W'(1);
                    end
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_req_valid <= n_req_valid;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_pos <= n_pend_pos;
        if (i_in_valid && !r_req_valid) begin
            r_op  <= t_op'(i_operation);
            r_pos <= i_position;
            r_val <= i_value_in;
        end
        if (w_emit) begin
            r_status    <= w_emit_status;
            r_data_out  <= w_emit_data;
            r_fpos      <= w_emit_fpos;
            r_count_now <= n_count;
            r_last      <= w_emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_data_out       = r_data_out;
    assign o_found_position = r_fpos;
    assign o_count_now      = r_count_now;
    assign o_last           = r_last;

    `OLIDF_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `OLIDF_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_idx <= r_count, "scan past count")
    `OLIDF_ASSERT_NOW(a_scan_holds_req, r_state == S_SCAN, r_req_valid, "scan without item")
    `OLIDF_ASSERT_NEXT(a_simple_retires, w_do_simple, !r_req_valid && o_out_valid,
        "item not retired")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import olidf_pkg::*;

    // Longest stretch with no item moving on either side before the run is
    // called hung. A find over a full list walks every cell before its last
    // result is loaded. Add the longest sender gap and the longest output
    // stall, and this limit is still many times over.
    localparam int QUIET_LIMIT = 2000;
    // Extra cycles to watch the output once every reply has come back.
    localparam int SETTLE_CYCLES = 20;

    // Op mix of the random part: grow the list, shrink it, or no preference.
    typedef enum int {
        BIAS_MIX,
        BIAS_GROW,
        BIAS_SHRINK
    } t_bias;

    // One list request. A hold entry makes the sender wait until every reply
    // has been taken.
    typedef struct {
        t_op                      op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        bit                       hold;
    } t_request;

    // One reply as the list must produce it.
    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         found_pos;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } t_reply;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_operation = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [DATA_W-1:0] i_value_in = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_data_out;
    logic [POS_W-1:0]         o_found_position;
    logic [CNT_W-1:0]         o_count_now;
    logic                     o_last;

    ordered_list_insert_delete_find u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value_in       (i_value_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_count_now      (o_count_now),
        .o_last           (o_last)
    );

    // Requests still to be sent, and replies owed by requests already taken.
    t_request request_q[$];
    t_reply   reply_q[$];

    // Shadow copy of the list, updated as each request is taken.
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;

    // Entry count as the request plan will leave it; steers positions while
    // the plan is built, before the run starts.
    int planned_len = 0;

    // Values that recur often, so finds hit one or many entries.
    logic signed [DATA_W-1:0] value_pool [6] = '{
        32'sh0000_0000, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd5, 32'sh5555_aaaa
    };

    int error_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;
    int quiet_cycles = 0;

    // Set with nonblocking writes, so a reader at the next edge sees a settled
    // value whatever order the clocked blocks run in.
    logic replies_settled = 1'b1;
    logic stimulus_done = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Apply one taken request to the shadow list and queue the replies it owes.
    task automatic apply_list_request(input t_op op, input logic [POS_W-1:0] pos,
                                      input logic signed [DATA_W-1:0] value);
        t_reply r;
        t_reply held;
        bit     have_held;
        int     p;
        int     j;
        p = int'(pos);
        r.status = ST_OK;
        r.data = '0;
        r.found_pos = '0;
        r.count = CNT_W'(list_len);
        r.last = 1'b1;
        have_held = 1'b0;
        case (op)
            OP_INSERT: begin
                // Full is checked before the position.
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (j = list_len; j >= p; j--) list_mem[j] = list_mem[j-1];
                    list_mem[p-1] = value;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = list_mem[p-1];
                    for (j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
                    list_len--;
                end
            end
            OP_OVERWRITE: begin
                if (p < 1 || p > list_len) r.status = ST_BADPOS;
                else list_mem[p-1] = value;
            end
            default: begin
                // Hold back each match until the next one shows it is not last.
                for (j = 0; j < list_len; j++) begin
                    if (list_mem[j] == value) begin
                        if (have_held) reply_q.push_back(held);
                        held = r;
                        held.found_pos = POS_W'(j + 1);
                        held.last = 1'b0;
                        have_held = 1'b1;
                    end
                end
                if (!have_held) r.status = ST_NOTFOUND;
            end
        endcase
        r.count = CNT_W'(list_len);
        if (have_held) begin
            held.count = CNT_W'(list_len);
            held.last = 1'b1;
            reply_q.push_back(held);
        end else begin
            reply_q.push_back(r);
        end
    endtask

    // Add a request to the plan and track the count it leaves behind.
    task automatic plan(input t_op op, input logic [POS_W-1:0] pos,
                        input logic signed [DATA_W-1:0] value);
        t_request q;
        q.op = op;
        q.pos = pos;
        q.value = value;
        q.hold = 1'b0;
        request_q.push_back(q);
        if (op == OP_INSERT && planned_len < CAPACITY && pos >= 1 && pos <= planned_len + 1)
            planned_len++;
        else if (op == OP_DELETE && pos >= 1 && pos <= planned_len)
            planned_len--;
    endtask

    task automatic plan_hold();
        t_request q;
        q.op = OP_FIND;
        q.pos = '0;
        q.value = '0;
        q.hold = 1'b1;
        request_q.push_back(q);
    endtask

    // Random request: mostly a legal position with pool values, the rest noise.
    task automatic plan_random(input t_bias bias);
        int                       r;
        int                       hi;
        t_op                      op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        r = $urandom_range(0, 99);
        case (bias)
            BIAS_GROW: begin
                if (r < 85) op = OP_INSERT;
                else if (r < 93) op = OP_FIND;
                else if (r < 97) op = OP_OVERWRITE;
                else op = OP_DELETE;
            end
            BIAS_SHRINK: begin
                if (r < 80) op = OP_DELETE;
                else if (r < 90) op = OP_FIND;
                else if (r < 96) op = OP_OVERWRITE;
                else op = OP_INSERT;
            end
            default: begin
                if (r < 25) op = OP_INSERT;
                else if (r < 50) op = OP_DELETE;
                else if (r < 75) op = OP_OVERWRITE;
                else op = OP_FIND;
            end
        endcase
        hi = (op == OP_INSERT) ? planned_len + 1 : planned_len;
        if (op != OP_FIND && hi >= 1 && $urandom_range(0, 99) < 85) begin
            pos = POS_W'($urandom_range(1, hi));
        end else begin
            case ($urandom_range(0, 3))
                0: pos = '0;
                1: pos = POS_W'(hi + 1);
                2: pos = POS_W'($urandom_range(65, 127));
                default: pos = POS_W'($urandom_range(0, 127));
            endcase
        end
        if ($urandom_range(0, 99) < 65) value = value_pool[$urandom_range(0, 5)];
        else value = $urandom;
        plan(op, pos, value);
    endtask

    // Idle cycles after each sent item: mostly none or short, a few long,
    // with calm runs of back-to-back items.
    function automatic int draw_send_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_calm = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output stall for the next cycle: short bursts mostly, a few long ones,
    // and calm runs with no stall at all.
    function automatic logic draw_stall();
        int r;
        if (stall_left > 0) begin
            stall_left--;
            return 1'b1;
        end
        if (stall_calm > 0) begin
            stall_calm--;
            return 1'b0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            stall_calm = $urandom_range(20, 60);
            return 1'b0;
        end
        if (r < 70) return 1'b0;
        if (r < 96) stall_left = $urandom_range(0, 2);
        else stall_left = $urandom_range(10, 30);
        return 1'b1;
    endfunction

    // Sender: drive one request at a time from the plan, hold it while
    // stalled, idle between items, and stop at a hold entry until every
    // reply has been taken.
    always @(posedge i_clk) begin
        t_request nxt;
        logic     next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                next_valid = 1'b0;
                send_gap = draw_send_gap();
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() > 0) begin
                    if (request_q[0].hold) begin
                        // replies_settled is registered; valid low means the
                        // last taken request is already counted in it.
                        if (!i_in_valid && replies_settled) void'(request_q.pop_front());
                    end else begin
                        nxt = request_q.pop_front();
                        i_operation <= nxt.op;
                        i_position <= nxt.pos;
                        i_value_in <= nxt.value;
                        next_valid = 1'b1;
                    end
                end
            end
            i_in_valid <= next_valid;
            stimulus_done <= (request_q.size() == 0) && !next_valid;
        end
    end

    // Receiver: check each taken reply against the oldest one owed, then
    // predict the replies of a request taken at this same edge. Doing both
    // here fixes their order.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            replies_settled <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("reply with none owed, status", o_status, 0);
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_data_out !== want.data)
                        report_mismatch("data_out", o_data_out, want.data);
                    if (o_found_position !== want.found_pos)
                        report_mismatch("found_position", o_found_position, want.found_pos);
                    if (o_count_now !== want.count)
                        report_mismatch("count_now", o_count_now, want.count);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
            if (i_in_valid && !o_in_stall)
                apply_list_request(t_op'(i_operation), i_position, i_value_in);
            replies_settled <= (reply_q.size() == 0);
            i_out_stall <= draw_stall();
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        int guard;

        // Directed part on an empty list: not found, bad positions, inserts at
        // front, middle and end with the value extremes, multi-match finds.
        plan(OP_FIND, 7'd0, 32'sd0);
        plan(OP_DELETE, 7'd1, 32'sd0);
        plan(OP_OVERWRITE, 7'd1, 32'sd9);
        plan(OP_INSERT, 7'd0, 32'sd1);
        plan(OP_INSERT, 7'd2, 32'sd1);
        plan(OP_INSERT, 7'd1, 32'sh7fff_ffff);
        plan(OP_INSERT, 7'd1, 32'sh8000_0000);
        plan(OP_INSERT, 7'd3, -32'sd1);
        plan(OP_INSERT, 7'd2, 32'sh7fff_ffff);
        plan(OP_FIND, 7'd127, 32'sh7fff_ffff);
        plan(OP_FIND, 7'd0, 32'sd0);
        plan(OP_OVERWRITE, 7'd4, 32'sh7fff_ffff);
        plan(OP_FIND, 7'd5, 32'sh7fff_ffff);
        plan(OP_OVERWRITE, 7'd5, 32'sd3);
        plan(OP_OVERWRITE, 7'd0, 32'sd3);
        plan(OP_INSERT, 7'd127, 32'sd3);
        plan(OP_DELETE, 7'd127, 32'sd0);
        plan(OP_DELETE, 7'd1, 32'sd0);
        plan(OP_DELETE, 7'd3, 32'sd0);
        plan(OP_DELETE, 7'd3, 32'sd0);
        plan(OP_FIND, 7'd0, 32'sh8000_0000);
        plan_hold();
        plan(OP_OVERWRITE, 7'd1, 32'sd0);
        plan(OP_FIND, 7'd64, 32'sd0);

        // Random part: fill the list, hit it while full, mix, shrink it to
        // half, mix.
        repeat (8) plan_random(BIAS_MIX);
        guard = 0;
        while (planned_len < CAPACITY && guard < 150) begin
            plan_random(BIAS_GROW);
            guard++;
        end
        repeat (4) plan(OP_INSERT, POS_W'($urandom_range(0, 127)), $urandom);
        plan_hold();
        repeat (8) plan_random(BIAS_MIX);
        guard = 0;
        while (planned_len > CAPACITY / 2 && guard < 150) begin
            plan_random(BIAS_SHRINK);
            guard++;
        end
        plan(OP_FIND, POS_W'($urandom_range(0, 127)), $urandom);
        repeat (8) plan_random(BIAS_MIX);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the plan to drain and every reply to arrive, then watch a
        // little longer for stray replies.
        do @(posedge i_clk); while (!(stimulus_done && replies_settled));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (reply_q.size() != 0)
            report_mismatch("replies never produced, count", 0, reply_q.size());
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
